@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL of the control register file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cpcrf_pkg.sv @@
// Types, constants and status stack helpers for the control register file.
package cpcrf_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned IDX_W    = 5;

  localparam logic [IDX_W-1:0] REG_BADVA  = 5'd8;
  localparam logic [IDX_W-1:0] REG_STATUS = 5'd12;
  localparam logic [IDX_W-1:0] REG_CAUSE  = 5'd13;
  localparam logic [IDX_W-1:0] REG_EPC    = 5'd14;

  typedef enum logic [1:0] {
    FUNC_IDLE   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_EXCEPT = 2'd2,
    FUNC_RETURN = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] cause_value;
    logic [DATA_W-1:0] fault_pc;
    logic [DATA_W-1:0] bad_address;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] return_pc;
    logic              interrupt_enable;
    logic              kernel_mode;
  } out_word_t;

  // push: low six bits become old [3:0] followed by 00
  function automatic logic [DATA_W-1:0] status_push(input logic [DATA_W-1:0] s);
    return {s[DATA_W-1:6], s[3:0], 2'b00};
  endfunction

  // pop: low four bits become old [5:2], [5:4] kept
  function automatic logic [DATA_W-1:0] status_pop(input logic [DATA_W-1:0] s);
    return {s[DATA_W-1:4], s[5:2]};
  endfunction

endpackage

@@ sv/cpcrf_if.sv @@
// Valid/ready channel interfaces for input and result words.
interface cpcrf_in_if;
  import cpcrf_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpcrf_out_if;
  import cpcrf_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/coprocessor_control_register_file_unit.sv @@
// Top level: system control coprocessor register file, 32 x 32 bits.
//
//   channel  dir  word                                   handshake
//   in_if    in   func, reg_index, write/cause/pc/badva  valid/ready
//   out_if   out  read_data, return_pc, ie, kernel       valid/ready
//
// One word per cycle sustained while out_if.ready stays high; an accepted word passes the input
// register, then the update and result register, and a stalled result holds it in between.
// rst_n (sync) clears all 32 registers and both valid flags.
// Register update happens when the input stage moves into the result register;
// a stalled result holds the input stage, which then holds in_if.ready low.
module coprocessor_control_register_file_unit (
  input logic          clk,
  input logic          rst_n,
  cpcrf_in_if.sink     in_if,
  cpcrf_out_if.source  out_if
);
  import cpcrf_pkg::*;

  `include "assert_macros.svh"

  in_word_t          s1_r;
  logic              s1_valid_r;
  out_word_t         out_r;
  out_word_t         out_nxt;
  logic              out_valid_r;
  logic              s1_adv;
  logic              in_ready;
  logic [DATA_W-1:0] regs_r   [NUM_REGS];
  logic [DATA_W-1:0] regs_nxt [NUM_REGS];

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  always_comb begin
    regs_nxt = regs_r;
    if (s1_adv) begin
      case (s1_r.func)
        FUNC_WRITE: begin
          regs_nxt[s1_r.reg_index] = s1_r.write_data;
        end
        FUNC_EXCEPT: begin
          regs_nxt[REG_CAUSE]  = s1_r.cause_value;
          regs_nxt[REG_EPC]    = s1_r.fault_pc;
          regs_nxt[REG_BADVA]  = s1_r.bad_address;
          regs_nxt[REG_STATUS] = status_push(regs_r[REG_STATUS]);
        end
        FUNC_RETURN: begin
          regs_nxt[REG_STATUS] = status_pop(regs_r[REG_STATUS]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_nxt.read_data        = regs_nxt[s1_r.reg_index];
    out_nxt.return_pc        = regs_nxt[REG_EPC];
    out_nxt.interrupt_enable = regs_nxt[REG_STATUS][0];
    out_nxt.kernel_mode      = regs_nxt[REG_STATUS][1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      regs_r      <= '{default: '0};
    end else begin
      regs_r <= regs_nxt;
      if (in_ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_if.valid) begin
      s1_r <= in_if.data;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  `ASSERT_NEXT(a_exc_epc, s1_adv && s1_r.func == FUNC_EXCEPT,
    out_if.data.return_pc == regs_r[REG_EPC] && regs_r[REG_EPC] == $past(s1_r.fault_pc),
    "exception did not load EPC")
  `ASSERT_NEXT(a_write_fwd, s1_adv && s1_r.func == FUNC_WRITE,
    out_if.data.read_data == $past(s1_r.write_data), "written word not visible in result")
  `ASSERT_NEXT(a_no_adv_hold, !s1_adv,
    $stable(regs_r[REG_STATUS]) && $stable(regs_r[REG_EPC]), "state changed without a word")
  `ASSERT_NOW(a_out_matches, out_valid_r,
    out_r.interrupt_enable == regs_r[REG_STATUS][0] && out_r.return_pc == regs_r[REG_EPC],
    "pending result out of step with register state")

endmodule
